// File: rtl/gfinv_pkg.sv
// Shared constants, types and helpers for the GF(2^8) inverse core.
package gfinv_pkg;

	localparam int ByteW    = 8;
	localparam int RemW     = 9;
	localparam int CoefW    = 16;
	localparam int DegW     = 4;
	localparam int MaxSteps = 16;
	localparam int CntW     = $clog2(MaxSteps + 1);

	localparam logic [RemW-1:0] FieldPoly = 9'h11B;

	typedef struct packed {
		logic load;
		logic step;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic r_is_one;
	} sts_t;

	// degree of a nonzero remainder; zero input returns 0
	function automatic logic [DegW-1:0] poly_deg(input logic [RemW-1:0] p);
		logic [DegW-1:0] d;
		d = '0;
		for (int i = 0; i < RemW; i++) begin
			if (p[i]) begin
				d = DegW'(i);
			end
		end
		return d;
	endfunction

endpackage

// File: rtl/gf256_inverse_extended_euclid_core.sv
// Top level of the GF(2^8) inverse core (AES polynomial 0x11B).
//
// Input channel: in_valid/in_ready with operand_byte. Output channel:
// out_valid/out_ready with inverse_byte. Zero maps to zero.
// Each accepted item runs the binary extended Euclid loop in the datapath,
// one shift-XOR step per cycle, until the remainder reaches one (at most
// fifteen steps, hard-capped at sixteen). The result then moves into an
// output register in the same cycle that the next item may be accepted.
// Only one item is in the loop at a time: the single step unit is shared,
// so the core takes no new item before the last one has finished its loop.
// A finished result waits in the output register; while it is not taken,
// the next item is still accepted and computed, and it holds at the end of
// its loop until the output register frees up, with in_ready low.
// Reset (arst_n low, asynchronous) drops any item in flight and clears
// out_valid; the core comes up idle with in_ready high.
module gf256_inverse_extended_euclid_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gfinv_pkg::ByteW-1:0] operand_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gfinv_pkg::ByteW-1:0] inverse_byte
);

	gfinv_pkg::cmd_t cmd;
	gfinv_pkg::sts_t sts;

	gfinv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gfinv_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.operand_byte (operand_byte),
		.inverse_byte (inverse_byte),
		.sts          (sts)
	);

endmodule

// File: rtl/gfinv_ctrl.sv
// Controller FSM: sequences load, Euclid steps and result capture.
module gfinv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  gfinv_pkg::sts_t     sts,
	output gfinv_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                     state_q;
	state_t                     state_d;
	logic [gfinv_pkg::CntW-1:0] cnt_q;
	logic                       out_valid_q;
	logic                       run;
	logic                       done;
	logic                       finish;

	assign run    = (state_q == ST_RUN);
	assign done   = sts.r_is_one || (cnt_q == gfinv_pkg::CntW'(gfinv_pkg::MaxSteps));
	assign finish = run && done && (!out_valid_q || out_ready);

	assign in_ready    = (state_q == ST_IDLE) || finish;
	assign cmd.load    = in_valid && in_ready;
	assign cmd.step    = run && !done;
	assign cmd.capture = finish;
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cmd.load) begin
					state_d = ST_RUN;
				end else if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!out_valid_q || out_ready))
		else $error("result captured over a pending item");

	a_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.capture))
		else $error("step and capture in the same cycle");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= gfinv_pkg::CntW'(gfinv_pkg::MaxSteps))
		else $error("step count past bound");

	a_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_RUN && cnt_q == '0))
		else $error("load did not start a run");

endmodule

// File: rtl/gfinv_dp.sv
// Datapath: remainder/cofactor pairs, one Euclid step per cycle, result register.
module gfinv_dp (
	input  logic                        clk,
	input  gfinv_pkg::cmd_t             cmd,
	input  logic [gfinv_pkg::ByteW-1:0] operand_byte,
	output logic [gfinv_pkg::ByteW-1:0] inverse_byte,
	output gfinv_pkg::sts_t             sts
);

	logic [gfinv_pkg::RemW-1:0]  r0_q, r1_q;
	logic [gfinv_pkg::CoefW-1:0] c0_q, c1_q;
	logic [gfinv_pkg::ByteW-1:0] inv_q;

	logic [gfinv_pkg::DegW-1:0]  d0, d1, sh;
	logic                        swap;
	logic [gfinv_pkg::RemW-1:0]  ra, rb;
	logic [gfinv_pkg::CoefW-1:0] ca, cb;

	always_comb begin
		d0   = gfinv_pkg::poly_deg(r0_q);
		d1   = gfinv_pkg::poly_deg(r1_q);
		swap = (d0 < d1);
		ra   = swap ? r1_q : r0_q;
		rb   = swap ? r0_q : r1_q;
		ca   = swap ? c1_q : c0_q;
		cb   = swap ? c0_q : c1_q;
		sh   = swap ? (d1 - d0) : (d0 - d1);
	end

	assign sts.r_is_one = (r0_q == gfinv_pkg::RemW'(1));
	assign inverse_byte = inv_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// zero has no inverse: start finished with a zero cofactor
			if (operand_byte == '0) begin
				r0_q <= gfinv_pkg::RemW'(1);
				c0_q <= '0;
			end else begin
				r0_q <= {1'b0, operand_byte};
				c0_q <= gfinv_pkg::CoefW'(1);
			end
			r1_q <= gfinv_pkg::FieldPoly;
			c1_q <= '0;
		end else if (cmd.step) begin
			r0_q <= ra ^ (rb << sh);
			c0_q <= ca ^ (cb << sh);
			r1_q <= rb;
			c1_q <= cb;
		end
		if (cmd.capture) begin
			inv_q <= c0_q[gfinv_pkg::ByteW-1:0];
		end
	end

endmodule

// File: sim/gfinv_checker.sv
// Checker for the GF(2^8) inverse core: predicts each inverse and compares results in order.
module gfinv_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [gfinv_pkg::ByteW-1:0] operand_byte,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [gfinv_pkg::ByteW-1:0] inverse_byte,
	output int unsigned                 mismatch_count,
	output int unsigned                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [gfinv_pkg::ByteW-1:0] inverse_q[$];
	logic [gfinv_pkg::ByteW-1:0] operand_q[$];

	// -1 for the zero polynomial
	function automatic int degree_of(input logic [15:0] p);
		int d;
		d = -1;
		for (int i = 0; i < 16; i++) begin
			if (p[i]) begin
				d = i;
			end
		end
		return d;
	endfunction

	function automatic logic [7:0] gf_inverse_of(input logic [7:0] a);
		logic [15:0] rem_a, rem_b, cof_a, cof_b, tmp;
		int deg_a, deg_b, tmp_deg;
		if (a == 8'h00) begin
			return 8'h00;
		end
		rem_a = 16'(a);
		rem_b = 16'(gfinv_pkg::FieldPoly);
		cof_a = 16'h0001;
		cof_b = 16'h0000;
		for (int k = 0; k < 16; k++) begin
			if (rem_a == 16'h0001) begin
				break;
			end
			deg_a = degree_of(rem_a);
			deg_b = degree_of(rem_b);
			if (deg_a < deg_b) begin
				tmp = rem_a; rem_a = rem_b; rem_b = tmp;
				tmp = cof_a; cof_a = cof_b; cof_b = tmp;
				tmp_deg = deg_a; deg_a = deg_b; deg_b = tmp_deg;
			end
			rem_a = rem_a ^ (rem_b << (deg_a - deg_b));
			cof_a = cof_a ^ (cof_b << (deg_a - deg_b));
		end
		return cof_a[7:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q.delete();
			operand_q.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (inverse_q.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("%0t: unexpected item, inverse_byte=%02h", $realtime,
							inverse_byte);
					end
					mismatch_count++;
				end else begin
					if (inverse_byte !== inverse_q[0]) begin
						if (mismatch_count < 10) begin
							$display("%0t: operand %02h: expected inverse %02h, got %02h",
								$realtime, operand_q[0], inverse_q[0], inverse_byte);
						end
						mismatch_count++;
					end
					void'(inverse_q.pop_front());
					void'(operand_q.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				inverse_q.push_back(gf_inverse_of(operand_byte));
				operand_q.push_back(operand_byte);
			end
			outstanding = inverse_q.size();
		end
	end

endmodule

// File: sim/tb_gf256_inverse_extended_euclid_core.sv
// Testbench top for the GF(2^8) inverse core: stimulus, output stalls, watchdog and verdict.
module tb_gf256_inverse_extended_euclid_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HoldCycles  = 300;
	localparam int IdleLimit   = 5000;
	localparam int TailCycles  = 40;
	localparam int PhaseItems  = 110;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [gfinv_pkg::ByteW-1:0] operand_byte;
	logic                        out_valid;
	logic                        out_ready;
	logic [gfinv_pkg::ByteW-1:0] inverse_byte;
	int unsigned                 mismatch_count;
	int unsigned                 outstanding;
	int                          gap_max;
	int                          stall_max;
	int                          idle_cycles;

	gf256_inverse_extended_euclid_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operand_byte (operand_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.inverse_byte (inverse_byte)
	);

	gfinv_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operand_byte   (operand_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.inverse_byte   (inverse_byte),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_operand(input logic [7:0] value, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operand_byte <= value;
		do begin
			@(posedge clk);
		end while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	function automatic logic [7:0] random_operand();
		logic [7:0] corner[4];
		corner = '{8'h00, 8'h01, 8'h80, 8'hFF};
		if ($urandom_range(0, 15) == 0) begin
			return corner[$urandom_range(0, 3)];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [7:0] directed[20];
		directed = '{8'h00, 8'h01, 8'hFF, 8'h80, 8'h02, 8'h03, 8'h53, 8'hCA,
			8'h8D, 8'hF6, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h1B,
			8'h8E, 8'h40, 8'h00};
		in_valid = 1'b0;
		operand_byte = '0;
		gap_max = 0;
		stall_max = 0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_operand(directed[i], $urandom_range(0, 2));
		end
		in_valid <= 1'b0;
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin gap_max = 0;  stall_max = 0;  end
				1: begin gap_max = 14; stall_max = 14; end
				2: begin gap_max = 0;  stall_max = 14; end
				3: begin gap_max = 14; stall_max = 0;  end
				4: begin gap_max = 4;  stall_max = 4;  end
				default: begin
					gap_max = $urandom_range(0, 14);
					stall_max = $urandom_range(0, 14);
				end
			endcase
			repeat (PhaseItems) begin
				send_operand(random_operand(), $urandom_range(0, gap_max));
			end
			if (ph == 2) begin
				in_valid <= 1'b0;
				wait_drained();
			end
		end
		in_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (TailCycles) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// output side; long hold-offs at two points fill the core and stall its input
	initial begin
		int stall;
		int taken;
		out_ready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken == 120 || taken == 450) begin
				stall = HoldCycles;
			end else begin
				stall = $urandom_range(0, stall_max);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!out_valid);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IdleLimit) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

endmodule
